// ----- design/sps_pkg.sv -----
package sps_pkg;

  localparam int unsigned EntryW = 36;

  typedef struct packed {
    logic [15:0] key;
    logic [2:0]  prio;
    logic        intr;
    logic [15:0] tag;
  } sps_entry_t;

  typedef enum logic [1:0] {
    MODE_SUBMIT   = 2'd0,
    MODE_COMPLETE = 2'd1,
    MODE_CANCEL   = 2'd2
  } sps_mode_e;

  typedef enum logic [3:0] {
    DEC_START    = 4'd0,
    DEC_PREEMPT  = 4'd1,
    DEC_QUEUED   = 4'd2,
    DEC_REPLACED = 4'd3,
    DEC_DROPPED  = 4'd4,
    DEC_NEXT     = 4'd5,
    DEC_IDLE     = 4'd6,
    DEC_NOOP     = 4'd7,
    DEC_CLEARED  = 4'd8
  } sps_dec_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_POST,
    ST_SEARCH,
    ST_DECIDE,
    ST_BEST,
    ST_COMPACT,
    ST_RESP
  } sps_state_e;

  localparam logic RegHint  = 1'b0;
  localparam logic RegFocus = 1'b1;

  // control of the shared compare unit
  typedef struct packed {
    logic clr;
    logic en;
    logic first;
  } sps_scan_ctl_t;

  // status flags from the shared compare unit
  typedef struct packed {
    logic dup;
    logic key_hit;
  } sps_scan_flags_t;

endpackage

// ----- design/sps_ram.sv -----
module sps_ram #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/sps_scan.sv -----
module sps_scan #(
  parameter int unsigned IW = 3
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sps_pkg::sps_scan_ctl_t  ctl_i,
  input  sps_pkg::sps_entry_t     ent_i,
  input  logic [IW-1:0]           idx_i,
  input  sps_pkg::sps_entry_t     ev_i,
  output sps_pkg::sps_scan_flags_t flags_o,
  output logic [IW-1:0]           key_idx_o,
  output logic [IW-1:0]           low_idx_o,
  output logic [2:0]              low_prio_o,
  output logic [IW-1:0]           best_idx_o,
  output sps_pkg::sps_entry_t     best_ent_o
);

  import sps_pkg::*;

  sps_scan_flags_t flags_q, flags_d;
  logic [IW-1:0]   key_idx_q, key_idx_d;
  logic [IW-1:0]   low_idx_q, low_idx_d;
  logic [2:0]      low_prio_q, low_prio_d;
  logic [IW-1:0]   best_idx_q, best_idx_d;
  sps_entry_t      best_ent_q, best_ent_d;
  logic            same_key;

  assign same_key = (ent_i.key == ev_i.key);

  always_comb begin
    flags_d    = flags_q;
    key_idx_d  = key_idx_q;
    low_idx_d  = low_idx_q;
    low_prio_d = low_prio_q;
    best_idx_d = best_idx_q;
    best_ent_d = best_ent_q;
    if (ctl_i.clr) begin
      flags_d = '0;
    end else if (ctl_i.en) begin
      if (same_key && ent_i.prio == ev_i.prio && ent_i.tag == ev_i.tag) begin
        flags_d.dup = 1'b1;
      end
      // first matching key wins
      if (same_key && !flags_q.key_hit) begin
        flags_d.key_hit = 1'b1;
        key_idx_d       = idx_i;
      end
      // lowest priority, first on ties
      if (ctl_i.first || ent_i.prio < low_prio_q) begin
        low_idx_d  = idx_i;
        low_prio_d = ent_i.prio;
      end
      // highest priority, first on ties
      if (ctl_i.first || ent_i.prio > best_ent_q.prio) begin
        best_idx_d = idx_i;
        best_ent_d = ent_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_idx_q  <= key_idx_d;
    low_idx_q  <= low_idx_d;
    low_prio_q <= low_prio_d;
    best_idx_q <= best_idx_d;
    best_ent_q <= best_ent_d;
  end

  assign flags_o    = flags_q;
  assign key_idx_o  = key_idx_q;
  assign low_idx_o  = low_idx_q;
  assign low_prio_o = low_prio_q;
  assign best_idx_o = best_idx_q;
  assign best_ent_o = best_ent_q;

endmodule

// ----- design/speech_priority_scheduler_core.sv -----
// channel | handshake               | payload
// --------+-------------------------+-----------------------------------------------
// in      | in_valid_i / in_stall_o | mode_i, event_key_i, event_priority_i,
//         |                         | event_interruptible_i, text_tag_i
// out     | out_valid_o / out_stall_i | decision_o, next_key_o, next_priority_o,
//         |                         | next_interruptible_o, next_tag_o
// cfg     | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// a complete runs a best-entry pass and a compaction pass over the pending entries;
// a submit that purges hints and then searches runs two passes
// the pending queue sits in a one-port-read ram, one entry is compared per cycle
// reset clears the active entry, speaking flag and fill count; queue entries need none
// in_stall_o is high while an item is at work; a finished result waits in the
// output register while the next item is taken
module speech_priority_scheduler_core #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] event_key_i,
  input  logic [2:0]  event_priority_i,
  input  logic        event_interruptible_i,
  input  logic [15:0] text_tag_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  decision_o,
  output logic [15:0] next_key_o,
  output logic [2:0]  next_priority_o,
  output logic        next_interruptible_o,
  output logic [15:0] next_tag_o
);

  import sps_pkg::*;

  localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // sequencer and architectural state
  sps_state_e      state_q, state_d;
  sps_mode_e       mode_q, mode_d;
  sps_entry_t      ev_q, ev_d;
  sps_dec_e        dec_q, dec_d;
  sps_entry_t      nxt_q, nxt_d;
  logic            speaking_q, speaking_d;
  sps_entry_t      act_q, act_d;
  logic [CW-1:0]   used_q, used_d;
  logic [2:0]      hint_q, focus_q;

  // scan pointers: read pointer, entry in flight, compaction write pointer
  logic [CW-1:0]   rd_q, rd_d;
  logic            pv_q, pv_d;
  logic [IW-1:0]   pidx_q, pidx_d;
  logic [CW-1:0]   wp_q, wp_d;
  logic            rm_q, rm_d;

  // output register
  logic            out_valid_q, out_valid_d;
  sps_dec_e        out_dec_q, out_dec_d;
  sps_entry_t      out_nxt_q, out_nxt_d;

  // ram port
  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  logic [IW-1:0]   ram_raddr;
  sps_entry_t      ram_wdata;
  logic [EntryW-1:0] ram_rdata;
  sps_entry_t      rd_ent;

  // compare unit
  sps_scan_ctl_t   scan_ctl;
  sps_scan_flags_t scan_flags;
  logic [IW-1:0]   key_idx, low_idx, best_idx;
  logic [2:0]      low_prio;
  sps_entry_t      best_ent;

  logic            in_acc;
  logic            rd_more;
  logic            scan_done;
  logic            keep;
  logic            dup_act;
  logic            preempt;

  assign rd_ent    = sps_entry_t'(ram_rdata);
  assign in_acc    = in_valid_i && (state_q == ST_IDLE);
  assign rd_more   = (rd_q < used_q);
  assign scan_done = !rd_more && !pv_q;

  // a purge pass drops hints, a removal pass drops the started entry
  assign keep = !(!rm_q && rd_ent.prio == hint_q) && !(rm_q && pidx_q == best_idx);

  assign dup_act = (act_q.key == ev_q.key) && (act_q.prio == ev_q.prio) &&
                   (act_q.tag == ev_q.tag);
  assign preempt = act_q.intr &&
                   ((ev_q.prio > act_q.prio) ||
                    (ev_q.key == act_q.key && ev_q.prio >= act_q.prio));

  sps_ram #(
    .WIDTH (EntryW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sps_scan #(
    .IW (IW)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (scan_ctl),
    .ent_i      (rd_ent),
    .idx_i      (pidx_q),
    .ev_i       (ev_q),
    .flags_o    (scan_flags),
    .key_idx_o  (key_idx),
    .low_idx_o  (low_idx),
    .low_prio_o (low_prio),
    .best_idx_o (best_idx),
    .best_ent_o (best_ent)
  );

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    ev_d        = ev_q;
    dec_d       = dec_q;
    nxt_d       = nxt_q;
    speaking_d  = speaking_q;
    act_d       = act_q;
    used_d      = used_q;
    rd_d        = rd_q;
    pv_d        = pv_q;
    pidx_d      = pidx_q;
    wp_d        = wp_q;
    rm_d        = rm_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_dec_d   = out_dec_q;
    out_nxt_d   = out_nxt_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = ev_q;
    ram_raddr   = rd_q[IW-1:0];
    scan_ctl    = '0;

    // shared read pipeline for every pass over the queue
    if (state_q == ST_SEARCH || state_q == ST_BEST || state_q == ST_COMPACT) begin
      if (rd_more) begin
        rd_d   = rd_q + 1'b1;
        pv_d   = 1'b1;
        pidx_d = rd_q[IW-1:0];
      end else begin
        pv_d = 1'b0;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          mode_d  = sps_mode_e'(mode_i);
          ev_d    = '{key: event_key_i, prio: event_priority_i,
                      intr: event_interruptible_i, tag: text_tag_i};
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        nxt_d   = '0;
        rd_d    = '0;
        pv_d    = 1'b0;
        wp_d    = '0;
        state_d = ST_RESP;
        unique case (mode_q)
          MODE_SUBMIT: begin
            if (ev_q.tag == '0) begin
              dec_d = DEC_DROPPED;
            end else if (ev_q.prio >= focus_q) begin
              rm_d    = 1'b0;
              state_d = ST_COMPACT;
            end else begin
              state_d = ST_POST;
            end
          end
          MODE_COMPLETE: begin
            if (!speaking_q) begin
              dec_d = DEC_NOOP;
            end else if (used_q == '0) begin
              speaking_d = 1'b0;
              act_d.tag  = '0;
              dec_d      = DEC_IDLE;
            end else begin
              state_d = ST_BEST;
            end
          end
          MODE_CANCEL: begin
            speaking_d = 1'b0;
            used_d     = '0;
            act_d.tag  = '0;
            dec_d      = DEC_CLEARED;
          end
          default: begin
            dec_d = DEC_NOOP;
          end
        endcase
      end
      ST_POST: begin
        rd_d = '0;
        pv_d = 1'b0;
        if (!speaking_q) begin
          act_d      = ev_q;
          speaking_d = 1'b1;
          dec_d      = DEC_START;
          state_d    = ST_RESP;
        end else begin
          scan_ctl.clr = 1'b1;
          state_d      = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        scan_ctl.en    = pv_q;
        scan_ctl.first = (pidx_q == '0);
        if (scan_done) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = ST_RESP;
        if (dup_act || scan_flags.dup) begin
          dec_d = DEC_DROPPED;
        end else if (preempt) begin
          act_d = ev_q;
          dec_d = DEC_PREEMPT;
        end else if (scan_flags.key_hit) begin
          ram_we    = 1'b1;
          ram_waddr = key_idx;
          dec_d     = DEC_REPLACED;
        end else if (used_q < CW'(QUEUE_DEPTH)) begin
          ram_we    = 1'b1;
          ram_waddr = used_q[IW-1:0];
          used_d    = used_q + 1'b1;
          dec_d     = DEC_QUEUED;
        end else if (ev_q.prio > low_prio) begin
          // full queue: evict the lowest entry
          ram_we    = 1'b1;
          ram_waddr = low_idx;
          dec_d     = DEC_REPLACED;
        end else begin
          dec_d = DEC_DROPPED;
        end
      end
      ST_BEST: begin
        scan_ctl.en    = pv_q;
        scan_ctl.first = (pidx_q == '0);
        if (scan_done) begin
          act_d   = best_ent;
          nxt_d   = best_ent;
          dec_d   = DEC_NEXT;
          rm_d    = 1'b1;
          rd_d    = '0;
          wp_d    = '0;
          state_d = ST_COMPACT;
        end
      end
      ST_COMPACT: begin
        // kept entries slide down to the write pointer
        if (pv_q && keep) begin
          ram_we    = 1'b1;
          ram_waddr = wp_q[IW-1:0];
          ram_wdata = rd_ent;
          wp_d      = wp_q + 1'b1;
        end
        if (scan_done) begin
          used_d  = wp_q;
          state_d = rm_q ? ST_RESP : ST_POST;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_dec_d   = dec_q;
          out_nxt_d   = nxt_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      speaking_q  <= 1'b0;
      act_q       <= '0;
      used_q      <= '0;
      rd_q        <= '0;
      pv_q        <= 1'b0;
      wp_q        <= '0;
      rm_q        <= 1'b0;
      out_valid_q <= 1'b0;
      hint_q      <= 3'd0;
      focus_q     <= 3'd2;
    end else begin
      state_q     <= state_d;
      speaking_q  <= speaking_d;
      act_q       <= act_d;
      used_q      <= used_d;
      rd_q        <= rd_d;
      pv_q        <= pv_d;
      wp_q        <= wp_d;
      rm_q        <= rm_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegHint:  hint_q  <= cfg_wdata_i;
          RegFocus: focus_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    ev_q      <= ev_d;
    dec_q     <= dec_d;
    nxt_q     <= nxt_d;
    pidx_q    <= pidx_d;
    out_dec_q <= out_dec_d;
    out_nxt_q <= out_nxt_d;
  end

  assign in_stall_o           = (state_q != ST_IDLE);
  assign out_valid_o          = out_valid_q;
  assign decision_o           = out_dec_q;
  assign next_key_o           = out_nxt_q.key;
  assign next_priority_o      = out_nxt_q.prio;
  assign next_interruptible_o = out_nxt_q.intr;
  assign next_tag_o           = out_nxt_q.tag;

  // fill count never exceeds the queue
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(QUEUE_DEPTH))
    else $error("pending fill count beyond queue depth");

  // compaction never writes ahead of the entry it moves
  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMPACT && pv_q) |-> (wp_q <= CW'(pidx_q)))
    else $error("compaction write pointer passed read position");

  // only a started event carries a payload
  a_next_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_dec_q != DEC_NEXT) |->
      (next_key_o == '0 && next_priority_o == '0 && next_interruptible_o == 1'b0 &&
       next_tag_o == '0))
    else $error("next fields set on a decision other than next started");

  // a result is loaded only from the response state
  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESP))
    else $error("result loaded outside the response state");

endmodule
